// ----- sv/tcp_rto_estimator_defines.svh -----
// assertion macros for the retransmission-timeout estimator
// no dependencies; included by the top level only
`ifndef TCP_RTO_ESTIMATOR_DEFINES_SVH
`define TCP_RTO_ESTIMATOR_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define TRTO_ASSERT_IMP(label, clk_sig, rstn_sig, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TRTO_ASSERT_NXT(label, clk_sig, rstn_sig, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/trto_pkg.sv -----
// shared codes, reset constants and register capping for the rto estimator
// no dependencies
package trto_pkg;

	// event kinds on the cmd field
	localparam logic [1:0] CMD_SAMPLE    = 2'd0;
	localparam logic [1:0] CMD_TIMEOUT   = 2'd1;
	localparam logic [1:0] CMD_HANDSHAKE = 2'd2;

	// result status codes
	typedef enum logic [1:0] {
		STATUS_ACCEPTED  = 2'd0,
		STATUS_INVALID   = 2'd1,
		STATUS_AMBIGUOUS = 2'd2,
		STATUS_DONE      = 2'd3
	} status_t;

	// configuration register indexes
	localparam logic [2:0] REG_INITIAL     = 3'd0;
	localparam logic [2:0] REG_MINIMUM     = 3'd1;
	localparam logic [2:0] REG_MAXIMUM     = 3'd2;
	localparam logic [2:0] REG_GRANULARITY = 3'd3;
	localparam logic [2:0] REG_SYN_FLOOR   = 3'd4;

	localparam int CFG_WIDTH = 31;

	// register reset values before capping
	localparam logic [CFG_WIDTH-1:0] INITIAL_RESET     = 31'd1000000;
	localparam logic [CFG_WIDTH-1:0] MINIMUM_RESET     = 31'd1000000;
	localparam logic [CFG_WIDTH-1:0] MAXIMUM_RESET     = 31'd60000000;
	localparam logic [CFG_WIDTH-1:0] GRANULARITY_RESET = 31'd1000;
	localparam logic [CFG_WIDTH-1:0] SYN_FLOOR_RESET   = 31'd3000000;

	// cap a register value at the largest positive duration of tw bits
	function automatic logic [CFG_WIDTH-1:0] cap_value(input logic [CFG_WIDTH-1:0] v,
			input int unsigned tw);
		logic [CFG_WIDTH:0] tmax;
		tmax = (32'd1 << (tw - 1)) - 32'd1;
		return ({1'b0, v} > tmax) ? tmax[CFG_WIDTH-1:0] : v;
	endfunction

endpackage

// ----- sv/tcp_rto_estimator.sv -----
// retransmission-timeout estimator, one event per cycle while the result channel is not stalled
// path: an event passes through the input register and then the result register to the outputs
// throughput: one event per cycle unless result_stall holds a full result register
// reset: timeout state loads the capped initial register value, estimates and marks clear
// depends on trto_pkg, trto_cfg_regs, trto_rtt_filter, trto_rto_clamp
`include "tcp_rto_estimator_defines.svh"
module tcp_rto_estimator #(
	parameter int TIME_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// event channel
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic [1:0]                     cmd,
	input  logic signed [31:0]             rtt_sample,
	input  logic                           was_retransmitted,
	input  logic                           timestamp_disambiguates,
	input  logic                           waiting_syn,
	// result channel
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [1:0]                     status,
	output logic [30:0]                    timeout_value,
	// configuration channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [2:0]                     cfg_index,
	input  logic [trto_pkg::CFG_WIDTH-1:0] cfg_data
);

	localparam int TW = (TIME_WIDTH < 32) ? TIME_WIDTH : 32;
	localparam int VW = TW - 1;

	localparam logic [trto_pkg::CFG_WIDTH-1:0] INIT_CAP =
		trto_pkg::cap_value(trto_pkg::INITIAL_RESET, TW);

	// configuration registers
	logic [VW-1:0] init_r, min_r, max_r, gran_r, floor_r;

	// input stage
	logic          v_s1;
	logic [1:0]    cmd_s1;
	logic [TW-1:0] rtt_s1;
	logic          resent_s1, stamped_s1, syn_s1;

	// estimator state
	logic [VW-1:0] srtt_q, rttvar_q, cur_timeout_q;
	logic          have_q, syn_resent_q;

	// result register
	logic             result_valid_q;
	trto_pkg::status_t status_q;
	logic [VW-1:0]    timeout_q;

	// next-state logic
	logic              adv;
	logic              sample_ok;
	logic [VW-1:0]     sample_val;
	logic [VW-1:0]     srtt_upd, rttvar_upd, rto_upd;
	logic [VW-1:0]     srtt_d, rttvar_d, timeout_d;
	logic              have_d, syn_resent_d;
	trto_pkg::status_t status_d;

	assign cfg_ready = 1'b1;

	trto_cfg_regs #(
		.TW (TW)
	) u_cfg_regs (
		.clk              (clk),
		.arst_n           (arst_n),
		.wr_en            (cfg_valid),
		.wr_index         (cfg_index),
		.wr_data          (cfg_data),
		.rto_initial      (init_r),
		.rto_lower        (min_r),
		.rto_upper        (max_r),
		.tick_granularity (gran_r),
		.syn_retry_floor  (floor_r)
	);

	// flow control: stage 1 moves on when the result register is free or drains
	assign adv        = v_s1 && (!result_valid_q || !result_stall);
	assign item_stall = v_s1 && !adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			cmd_s1     <= cmd;
			rtt_s1     <= rtt_sample[TW-1:0];
			resent_s1  <= was_retransmitted;
			stamped_s1 <= timestamp_disambiguates;
			syn_s1     <= waiting_syn;
		end
	end

	// sample decode: positive values only
	assign sample_ok  = !rtt_s1[TW-1] && (|rtt_s1);
	assign sample_val = rtt_s1[VW-1:0];

	trto_rtt_filter #(
		.VW (VW)
	) u_rtt_filter (
		.have_measurement (have_q),
		.sample           (sample_val),
		.srtt             (srtt_q),
		.rttvar           (rttvar_q),
		.srtt_next        (srtt_upd),
		.rttvar_next      (rttvar_upd)
	);

	trto_rto_clamp #(
		.VW (VW)
	) u_rto_clamp (
		.srtt             (srtt_upd),
		.rttvar           (rttvar_upd),
		.rto_lower        (min_r),
		.rto_upper        (max_r),
		.tick_granularity (gran_r),
		.timeout          (rto_upd)
	);

	// event handling
	always_comb begin
		srtt_d       = srtt_q;
		rttvar_d     = rttvar_q;
		timeout_d    = cur_timeout_q;
		have_d       = have_q;
		syn_resent_d = syn_resent_q;
		status_d     = trto_pkg::STATUS_DONE;
		case (cmd_s1)
			trto_pkg::CMD_SAMPLE: begin
				if (!sample_ok) begin
					status_d = trto_pkg::STATUS_INVALID;
				end else if (resent_s1 && !stamped_s1) begin
					status_d = trto_pkg::STATUS_AMBIGUOUS;
				end else begin
					srtt_d    = srtt_upd;
					rttvar_d  = rttvar_upd;
					have_d    = 1'b1;
					timeout_d = rto_upd;
					status_d  = trto_pkg::STATUS_ACCEPTED;
				end
			end
			trto_pkg::CMD_TIMEOUT: begin
				// backoff doubles, saturating at the maximum
				if (cur_timeout_q >= (max_r >> 1)) begin
					timeout_d = max_r;
				end else begin
					timeout_d = cur_timeout_q << 1;
				end
				if (syn_s1) begin
					syn_resent_d = 1'b1;
				end
			end
			trto_pkg::CMD_HANDSHAKE: begin
				if (syn_resent_q && (cur_timeout_q < floor_r)) begin
					timeout_d = floor_r;
				end
				syn_resent_d = 1'b0;
			end
			default: ;
		endcase
	end

	// estimator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srtt_q        <= '0;
			rttvar_q      <= '0;
			cur_timeout_q <= INIT_CAP[VW-1:0];
			have_q        <= 1'b0;
			syn_resent_q  <= 1'b0;
		end else if (adv) begin
			srtt_q        <= srtt_d;
			rttvar_q      <= rttvar_d;
			cur_timeout_q <= timeout_d;
			have_q        <= have_d;
			syn_resent_q  <= syn_resent_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q  <= status_d;
			timeout_q <= timeout_d;
		end
	end

	assign result_valid  = result_valid_q;
	assign status        = status_q;
	assign timeout_value = 31'(timeout_q);

	// checks
	`TRTO_ASSERT_IMP(a_no_estimate_before_sample, clk, arst_n, !have_q, (srtt_q == '0) && (rttvar_q == '0), "estimator state set without a measurement")
	`TRTO_ASSERT_NXT(a_result_tracks_state, clk, arst_n, adv, timeout_q == cur_timeout_q, "result timeout differs from timeout state")
	`TRTO_ASSERT_NXT(a_accepted_within_max, clk, arst_n, adv && (status_d == trto_pkg::STATUS_ACCEPTED), have_q && (cur_timeout_q <= max_r), "accepted sample left timeout above maximum")

endmodule

// ----- sv/trto_cfg_regs.sv -----
// configuration register file: five capped timeout registers
// depends on trto_pkg
module trto_cfg_regs #(
	parameter int TW = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [2:0]                        wr_index,
	input  logic [trto_pkg::CFG_WIDTH-1:0]    wr_data,
	output logic [TW-2:0]                     rto_initial,
	output logic [TW-2:0]                     rto_lower,
	output logic [TW-2:0]                     rto_upper,
	output logic [TW-2:0]                     tick_granularity,
	output logic [TW-2:0]                     syn_retry_floor
);

	localparam int VW = TW - 1;

	localparam logic [trto_pkg::CFG_WIDTH-1:0] INIT_CAP =
		trto_pkg::cap_value(trto_pkg::INITIAL_RESET, TW);
	localparam logic [trto_pkg::CFG_WIDTH-1:0] MIN_CAP =
		trto_pkg::cap_value(trto_pkg::MINIMUM_RESET, TW);
	localparam logic [trto_pkg::CFG_WIDTH-1:0] MAX_CAP =
		trto_pkg::cap_value(trto_pkg::MAXIMUM_RESET, TW);
	localparam logic [trto_pkg::CFG_WIDTH-1:0] GRAN_CAP =
		trto_pkg::cap_value(trto_pkg::GRANULARITY_RESET, TW);
	localparam logic [trto_pkg::CFG_WIDTH-1:0] FLOOR_CAP =
		trto_pkg::cap_value(trto_pkg::SYN_FLOOR_RESET, TW);

	logic [trto_pkg::CFG_WIDTH-1:0] capped;
	logic [VW-1:0]                  init_q, min_q, max_q, gran_q, floor_q;

	// cap the written value to the time width
	always_comb begin
		capped = trto_pkg::cap_value(wr_data, TW);
	end

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q  <= INIT_CAP[VW-1:0];
			min_q   <= MIN_CAP[VW-1:0];
			max_q   <= MAX_CAP[VW-1:0];
			gran_q  <= GRAN_CAP[VW-1:0];
			floor_q <= FLOOR_CAP[VW-1:0];
		end else if (wr_en) begin
			case (wr_index)
				trto_pkg::REG_INITIAL:     init_q  <= capped[VW-1:0];
				trto_pkg::REG_MINIMUM:     min_q   <= capped[VW-1:0];
				trto_pkg::REG_MAXIMUM:     max_q   <= capped[VW-1:0];
				trto_pkg::REG_GRANULARITY: gran_q  <= capped[VW-1:0];
				trto_pkg::REG_SYN_FLOOR:   floor_q <= capped[VW-1:0];
				default: ;
			endcase
		end
	end

	assign rto_initial      = init_q;
	assign rto_lower        = min_q;
	assign rto_upper        = max_q;
	assign tick_granularity = gran_q;
	assign syn_retry_floor  = floor_q;

endmodule

// ----- sv/trto_rtt_filter.sv -----
// smoothed rtt and rtt variation update for one accepted sample
// depends on nothing; purely combinational
module trto_rtt_filter #(
	parameter int VW = 31
) (
	input  logic          have_measurement,
	input  logic [VW-1:0] sample,
	input  logic [VW-1:0] srtt,
	input  logic [VW-1:0] rttvar,
	output logic [VW-1:0] srtt_next,
	output logic [VW-1:0] rttvar_next
);

	logic [VW-1:0]        abs_err;
	logic signed [VW:0]   var_err, var_sum, var_step, var_new;
	logic signed [VW:0]   avg_err, avg_sum, avg_step, avg_new;

	always_comb begin
		// magnitude of the error against the old average
		abs_err = (sample >= srtt) ? (sample - srtt) : (srtt - sample);

		// variation gain 1/4, truncated toward zero
		var_err  = $signed({1'b0, abs_err}) - $signed({1'b0, rttvar});
		var_sum  = var_err + $signed({{(VW-1){1'b0}}, var_err[VW], var_err[VW]});
		var_step = var_sum >>> 2;
		var_new  = $signed({1'b0, rttvar}) + var_step;

		// average gain 1/8, truncated toward zero
		avg_err  = $signed({1'b0, sample}) - $signed({1'b0, srtt});
		avg_sum  = avg_err + $signed({{(VW-2){1'b0}}, {3{avg_err[VW]}}});
		avg_step = avg_sum >>> 3;
		avg_new  = $signed({1'b0, srtt}) + avg_step;

		// first sample seeds both terms
		if (!have_measurement) begin
			srtt_next   = sample;
			rttvar_next = sample >> 1;
		end else begin
			srtt_next   = avg_new[VW-1:0];
			rttvar_next = var_new[VW-1:0];
		end
	end

endmodule

// ----- sv/trto_rto_clamp.sv -----
// timeout from srtt and variation: srtt + max(g, 4*rttvar), clamped
// overflow-safe against the maximum; purely combinational
module trto_rto_clamp #(
	parameter int VW = 31
) (
	input  logic [VW-1:0] srtt,
	input  logic [VW-1:0] rttvar,
	input  logic [VW-1:0] rto_lower,
	input  logic [VW-1:0] rto_upper,
	input  logic [VW-1:0] tick_granularity,
	output logic [VW-1:0] timeout
);

	logic [VW-1:0] headroom;
	logic [VW+1:0] var4, term;
	logic [VW+1:0] total;
	logic          saturate;
	logic [VW-1:0] low_clamped;

	always_comb begin
		// room left below the maximum
		headroom = rto_upper - srtt;
		var4     = {rttvar, 2'b00};
		term     = (var4 < {2'b00, tick_granularity}) ? {2'b00, tick_granularity} : var4;
		saturate = (srtt >= rto_upper) || (rttvar > (headroom >> 2)) ||
			(term > {2'b00, headroom});
		total    = {2'b00, srtt} + term;

		// lower clamp first, then upper clamp wins
		low_clamped = (total < {2'b00, rto_lower}) ? rto_lower : total[VW-1:0];
		if (saturate) begin
			timeout = rto_upper;
		end else if (low_clamped > rto_upper) begin
			timeout = rto_upper;
		end else begin
			timeout = low_clamped;
		end
	end

endmodule

// ----- tb/tcp_rto_estimator_tb.sv -----
// self-checking testbench for the tcp_rto_estimator retransmission-timeout block
// directed and random event streams checked against an in-bench estimator model
// depends on trto_pkg and the tcp_rto_estimator rtl
module tcp_rto_estimator_tb;

	// cmd value with no meaning, must leave the state alone
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [trto_pkg::CFG_WIDTH-1:0] LIMIT_TOP = 31'h7FFF_FFFF;
	localparam int unsigned RESET_CYCLES = 12;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned RANDOM_PHASES = 9;
	localparam int unsigned PHASE_EVENTS = 200;
	localparam int unsigned MAX_REPORTS = 10;

	typedef struct packed {
		trto_pkg::status_t              code;
		logic [trto_pkg::CFG_WIDTH-1:0] rto;
	} rto_outcome_t;

	logic                           clk;
	logic                           arst_n;
	logic                           item_valid;
	logic                           item_stall;
	logic [1:0]                     cmd;
	logic signed [31:0]             rtt_sample;
	logic                           was_retransmitted;
	logic                           timestamp_disambiguates;
	logic                           waiting_syn;
	logic                           result_valid;
	logic                           result_stall;
	logic [1:0]                     status;
	logic [30:0]                    timeout_value;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [2:0]                     cfg_index;
	logic [trto_pkg::CFG_WIDTH-1:0] cfg_data;

	// estimator model state and register copies
	longint est_srtt, est_rttvar, est_rto;
	bit     est_measured, est_syn_mark;
	longint lim_initial, lim_min, lim_max, lim_gran, lim_syn_floor;

	rto_outcome_t pending_results[$];
	int  mismatch_count;
	int  results_checked;
	int  register_writes;
	int  kind_seen[4];
	bit  pace_on;

	tcp_rto_estimator dut (
		.clk                     (clk),
		.arst_n                  (arst_n),
		.item_valid              (item_valid),
		.item_stall              (item_stall),
		.cmd                     (cmd),
		.rtt_sample              (rtt_sample),
		.was_retransmitted       (was_retransmitted),
		.timestamp_disambiguates (timestamp_disambiguates),
		.waiting_syn             (waiting_syn),
		.result_valid            (result_valid),
		.result_stall            (result_stall),
		.status                  (status),
		.timeout_value           (timeout_value),
		.cfg_valid               (cfg_valid),
		.cfg_ready               (cfg_ready),
		.cfg_index               (cfg_index),
		.cfg_data                (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// idle length: mostly none, sometimes a few cycles, rarely a long pause
	function automatic int unsigned idle_length();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 70)
			return 0;
		if (roll < 95)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// random single bit
	function automatic logic coin_flip();
		return $urandom_range(1) != 0;
	endfunction

	// register value: low bound, top of range or a typical value
	function automatic logic [trto_pkg::CFG_WIDTH-1:0] limit_value(int unsigned lo,
			int unsigned typ_hi);
		int unsigned roll, pick;
		roll = $urandom_range(99);
		if (roll < 10)
			return lo[trto_pkg::CFG_WIDTH-1:0];
		if (roll < 20)
			return LIMIT_TOP;
		pick = $urandom_range(typ_hi, lo);
		return pick[trto_pkg::CFG_WIDTH-1:0];
	endfunction

	// estimator model: update state for one event, return the expected result
	function automatic rto_outcome_t estimate_event(logic [1:0] kind, logic signed [31:0] sample,
			logic resent, logic stamped, logic syn);
		longint r, dev, term;
		rto_outcome_t res;
		res.code = trto_pkg::STATUS_DONE;
		r = longint'(sample);
		case (kind)
			trto_pkg::CMD_SAMPLE: begin
				if (r <= 0) begin
					res.code = trto_pkg::STATUS_INVALID;
				end else if (resent && !stamped) begin
					res.code = trto_pkg::STATUS_AMBIGUOUS;
				end else begin
					// first measurement seeds the filters, later ones smooth them
					if (!est_measured) begin
						est_srtt = r;
						est_rttvar = r / 2;
						est_measured = 1'b1;
					end else begin
						dev = (r >= est_srtt) ? r - est_srtt : est_srtt - r;
						est_rttvar += (dev - est_rttvar) / 4;
						est_srtt += (r - est_srtt) / 8;
					end
					// srtt + max(g, 4*rttvar) without overflow, min clamp then max clamp
					if (est_srtt >= lim_max || est_rttvar > (lim_max - est_srtt) / 4) begin
						est_rto = lim_max;
					end else begin
						term = est_rttvar * 4;
						if (term < lim_gran)
							term = lim_gran;
						if (term > lim_max - est_srtt) begin
							est_rto = lim_max;
						end else begin
							term += est_srtt;
							if (term < lim_min)
								term = lim_min;
							if (term > lim_max)
								term = lim_max;
							est_rto = term;
						end
					end
					res.code = trto_pkg::STATUS_ACCEPTED;
				end
			end
			trto_pkg::CMD_TIMEOUT: begin
				// exponential backoff saturating at the maximum
				if (est_rto >= lim_max / 2)
					est_rto = lim_max;
				else
					est_rto = est_rto * 2;
				if (syn)
					est_syn_mark = 1'b1;
			end
			trto_pkg::CMD_HANDSHAKE: begin
				if (est_syn_mark && est_rto < lim_syn_floor)
					est_rto = lim_syn_floor;
				est_syn_mark = 1'b0;
			end
			default: ;
		endcase
		res.rto = est_rto[trto_pkg::CFG_WIDTH-1:0];
		return res;
	endfunction

	// one event transfer, with an optional idle gap in front
	task automatic send_event(input logic [1:0] kind, input logic [31:0] sample,
			input logic resent, input logic stamped, input logic syn);
		int unsigned gap;
		gap = pace_on ? idle_length() : 0;
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		cmd <= kind;
		rtt_sample <= sample;
		was_retransmitted <= resent;
		timestamp_disambiguates <= stamped;
		waiting_syn <= syn;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	// stop sending and wait until every expected result has come back
	task automatic drain_results();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one register write transfer, only while the block is idle
	task automatic write_register(input logic [2:0] idx,
			input logic [trto_pkg::CFG_WIDTH-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// reset config: every command and every sample class
	task automatic test_directed_events();
		send_event(CMD_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
		send_event(trto_pkg::CMD_HANDSHAKE, 32'd0, 1'b0, 1'b0, 1'b0);
		send_event(trto_pkg::CMD_SAMPLE, 32'd0, 1'b0, 1'b1, 1'b0);
		send_event(trto_pkg::CMD_SAMPLE, 32'h8000_0000, 1'b0, 1'b0, 1'b0);
		send_event(trto_pkg::CMD_SAMPLE, 32'd5000, 1'b1, 1'b0, 1'b0);
		send_event(trto_pkg::CMD_TIMEOUT, 32'd0, 1'b0, 1'b0, 1'b1);
		send_event(trto_pkg::CMD_HANDSHAKE, 32'd0, 1'b0, 1'b0, 1'b0);
		send_event(trto_pkg::CMD_SAMPLE, 32'd200000, 1'b1, 1'b1, 1'b0);
		send_event(trto_pkg::CMD_SAMPLE, 32'd1, 1'b0, 1'b1, 1'b1);
		send_event(trto_pkg::CMD_SAMPLE, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0);
		repeat (4) send_event(trto_pkg::CMD_TIMEOUT, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0);
		drain_results();
	endtask

	// extreme register settings, including minimum above maximum
	task automatic test_register_extremes();
		logic [2:0]  idx;
		logic [31:0] junk;
		write_register(trto_pkg::REG_GRANULARITY, '0);
		write_register(trto_pkg::REG_MINIMUM, 31'd1);
		write_register(trto_pkg::REG_MAXIMUM, LIMIT_TOP);
		write_register(trto_pkg::REG_SYN_FLOOR, LIMIT_TOP);
		write_register(trto_pkg::REG_INITIAL, LIMIT_TOP);
		send_event(trto_pkg::CMD_SAMPLE, 32'd3, 1'b0, 1'b0, 1'b0);
		send_event(trto_pkg::CMD_TIMEOUT, 32'd0, 1'b0, 1'b0, 1'b1);
		send_event(trto_pkg::CMD_TIMEOUT, 32'd0, 1'b0, 1'b0, 1'b1);
		send_event(trto_pkg::CMD_HANDSHAKE, 32'd0, 1'b0, 1'b0, 1'b0);
		send_event(trto_pkg::CMD_SAMPLE, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0);
		drain_results();

		// maximum below minimum: maximum wins
		write_register(trto_pkg::REG_MINIMUM, LIMIT_TOP);
		write_register(trto_pkg::REG_MAXIMUM, 31'd1);
		write_register(trto_pkg::REG_GRANULARITY, LIMIT_TOP);
		write_register(trto_pkg::REG_SYN_FLOOR, '0);
		write_register(trto_pkg::REG_INITIAL, 31'd1);
		send_event(trto_pkg::CMD_SAMPLE, 32'd100, 1'b0, 1'b0, 1'b0);
		send_event(trto_pkg::CMD_TIMEOUT, 32'd0, 1'b0, 1'b0, 1'b1);
		send_event(trto_pkg::CMD_HANDSHAKE, 32'd0, 1'b0, 1'b0, 1'b0);
		drain_results();

		// writes to unassigned indexes, then back to the reset values
		idx = trto_pkg::REG_SYN_FLOOR;
		repeat (3) begin
			idx++;
			junk = $urandom();
			write_register(idx, junk[trto_pkg::CFG_WIDTH-1:0]);
		end
		write_register(trto_pkg::REG_INITIAL, trto_pkg::INITIAL_RESET);
		write_register(trto_pkg::REG_MINIMUM, trto_pkg::MINIMUM_RESET);
		write_register(trto_pkg::REG_MAXIMUM, trto_pkg::MAXIMUM_RESET);
		write_register(trto_pkg::REG_GRANULARITY, trto_pkg::GRANULARITY_RESET);
		write_register(trto_pkg::REG_SYN_FLOOR, trto_pkg::SYN_FLOOR_RESET);
		send_event(trto_pkg::CMD_SAMPLE, 32'd50000, 1'b0, 1'b1, 1'b0);
		send_event(trto_pkg::CMD_TIMEOUT, 32'd0, 1'b0, 1'b0, 1'b0);
		send_event(trto_pkg::CMD_HANDSHAKE, 32'd0, 1'b0, 1'b0, 1'b0);
		drain_results();
	endtask

	// phases of random traffic, each under its own random register setting
	task automatic test_random_traffic();
		int unsigned base, roll;
		logic [31:0] sample;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			write_register(trto_pkg::REG_INITIAL, limit_value(1, 5000000));
			write_register(trto_pkg::REG_MINIMUM, limit_value(1, 2000000));
			write_register(trto_pkg::REG_MAXIMUM, limit_value(1, 120000000));
			write_register(trto_pkg::REG_GRANULARITY, limit_value(0, 100000));
			write_register(trto_pkg::REG_SYN_FLOOR, limit_value(0, 10000000));
			// every third phase runs both sides without idling
			pace_on = (phase % 3 != 0);
			base = $urandom_range(1000000, 50);
			for (int n = 0; n < PHASE_EVENTS; n++) begin
				roll = $urandom_range(99);
				if (roll < 68) begin
					// sample classes: around the path rtt, tiny, huge, non-positive, any
					roll = $urandom_range(99);
					if (roll < 55)
						sample = base / 2 + $urandom_range(base);
					else if (roll < 65)
						sample = $urandom_range(100, 1);
					else if (roll < 75)
						sample = $urandom_range(32'h7FFF_FFFF, 32'h4000_0000);
					else if (roll < 85)
						sample = $urandom_range(1) ? 32'd0 : ($urandom() | 32'h8000_0000);
					else
						sample = $urandom();
					send_event(trto_pkg::CMD_SAMPLE, sample, $urandom_range(99) < 20,
						coin_flip(), coin_flip());
				end else if (roll < 84) begin
					send_event(trto_pkg::CMD_TIMEOUT, $urandom(), coin_flip(),
						coin_flip(), $urandom_range(99) < 40);
				end else if (roll < 96) begin
					send_event(trto_pkg::CMD_HANDSHAKE, $urandom(), coin_flip(),
						coin_flip(), coin_flip());
				end else begin
					send_event(CMD_UNUSED, $urandom(), coin_flip(),
						coin_flip(), coin_flip());
				end
			end
			drain_results();
		end
	endtask

	// result channel backpressure
	initial begin : result_backpressure
		int unsigned stall_left;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (!pace_on)
				stall_left = 0;
			else if (stall_left == 0)
				stall_left = idle_length();
			result_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	// scoreboard: check result transfers, predict on event transfers, track writes
	always @(posedge clk) begin : scoreboard
		rto_outcome_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				results_checked++;
				if (pending_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("unexpected result: status %0d timeout %0d",
							status, timeout_value);
				end else begin
					want = pending_results.pop_front();
					if (status !== want.code || timeout_value !== want.rto) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS)
							$display("result %0d: expected status %0d timeout %0d, %s %0d %s %0d",
								results_checked, want.code, want.rto,
								"got status", status, "timeout", timeout_value);
					end
				end
			end
			if (item_valid && !item_stall) begin
				kind_seen[cmd]++;
				pending_results.push_back(estimate_event(cmd, rtt_sample, was_retransmitted,
					timestamp_disambiguates, waiting_syn));
			end
			if (cfg_valid && cfg_ready) begin
				register_writes++;
				// a write never reloads the timeout state
				case (cfg_index)
					trto_pkg::REG_INITIAL:     lim_initial = longint'(cfg_data);
					trto_pkg::REG_MINIMUM:     lim_min = longint'(cfg_data);
					trto_pkg::REG_MAXIMUM:     lim_max = longint'(cfg_data);
					trto_pkg::REG_GRANULARITY: lim_gran = longint'(cfg_data);
					trto_pkg::REG_SYN_FLOOR:   lim_syn_floor = longint'(cfg_data);
					default: ;
				endcase
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin : watchdog
		int unsigned quiet_cycles;
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", quiet_cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		cmd = trto_pkg::CMD_SAMPLE;
		rtt_sample = '0;
		was_retransmitted = 1'b0;
		timestamp_disambiguates = 1'b0;
		waiting_syn = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = trto_pkg::REG_INITIAL;
		cfg_data = '0;
		pace_on = 1'b1;
		lim_initial = longint'(trto_pkg::INITIAL_RESET);
		lim_min = longint'(trto_pkg::MINIMUM_RESET);
		lim_max = longint'(trto_pkg::MAXIMUM_RESET);
		lim_gran = longint'(trto_pkg::GRANULARITY_RESET);
		lim_syn_floor = longint'(trto_pkg::SYN_FLOOR_RESET);
		est_srtt = 0;
		est_rttvar = 0;
		est_rto = longint'(trto_pkg::INITIAL_RESET);
		est_measured = 1'b0;
		est_syn_mark = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_events();
		test_register_extremes();
		test_random_traffic();

		// wait out the pipeline after the last transfer
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d rtt samples, %0d timer expiries, %0d handshakes, %0d unused commands",
			kind_seen[trto_pkg::CMD_SAMPLE], kind_seen[trto_pkg::CMD_TIMEOUT],
			kind_seen[trto_pkg::CMD_HANDSHAKE], kind_seen[CMD_UNUSED]);
		$display("%0d register writes, %0d results checked, %0d mismatches, %0d missing",
			register_writes, results_checked, mismatch_count, pending_results.size());
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/trto_pkg.sv
sv/trto_cfg_regs.sv
sv/trto_rtt_filter.sv
sv/trto_rto_clamp.sv
sv/tcp_rto_estimator.sv
tb/tcp_rto_estimator_tb.sv
